// ----- src/multi_class_two_priority_queue_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-class two-priority queue core
// Shared property forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_CLASS_TWO_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MULTI_CLASS_TWO_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define MCTPQ_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCTPQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/mctpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mctpq_pkg
// Types, codes and port layout constants for the multi-class queue core.
// ----------------------------------------------------------------------------
package mctpq_pkg;

   // port layout
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int QIDX_W     = 5;
   localparam int ID_FIELD_W = 16;
   localparam int OCC_W      = 4;
   localparam int QIDX_SPAN  = 32;

   // request kinds
   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_POP
   } fsm_state_type;

   typedef struct packed {
      logic req_fire;
      logic take_entry;
      logic out_free;
   } fsm_status_type;

   typedef struct packed {
      logic req_ready;
      logic exec_commit;
      logic pop_read;
      logic result_load;
      logic from_pop;
   } fsm_ctrl_type;

endpackage

// ----- src/mctpq_ram.sv -----
// ----------------------------------------------------------------------------
// mctpq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mctpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mctpq_fsm.sv -----
// ----------------------------------------------------------------------------
// mctpq_fsm
// Sequencer: read queue state, commit, optional entry read, deliver result.
// ----------------------------------------------------------------------------
module mctpq_fsm (
   input  logic                     clock,
   input  logic                     reset,
   input  mctpq_pkg::fsm_status_type status,
   output mctpq_pkg::fsm_ctrl_type   ctrl
);
   import mctpq_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (status.req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (status.take_entry) begin
               state_in = S_POP;
            end else if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctrl.req_ready = 1'b1;
         end
         S_EXEC: begin
            ctrl.exec_commit = status.take_entry | status.out_free;
            ctrl.pop_read    = status.take_entry;
            ctrl.result_load = ~status.take_entry & status.out_free;
         end
         S_POP: begin
            ctrl.result_load = status.out_free;
            ctrl.from_pop    = 1'b1;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

// ----- src/multi_class_two_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// multi_class_two_priority_queue_core
// Bank of bounded queues with urgent insert at the head, held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ stream carries one command word: add an item to a queue (urgent
//   at the head, normal at the tail) or remove the head of a queue. Every
//   word yields exactly one rsp_ word with a status, the popped item (zero
//   when nothing was removed) and the queue's occupancy after the command.
//   Queue indexes at or above QUEUE_COUNT wrap modulo QUEUE_COUNT.
//   Timing: one command at a time. An add or a rejected command ends in
//   the exec state, a successful remove adds a pop state, because the
//   head pointer must come out of the queue-state RAM before the entry RAM
//   can be read at it. The next word is accepted the cycle after a result
//   is loaded into the output register.
//   Stall: the result waits in the output register; a new word is still
//   accepted and runs up to its final step, where it holds until the
//   output register frees.
//   Reset: all queues read as empty at once (a valid bit per queue, no
//   clearing pass); entry contents are left undefined and are only ever
//   read from occupied slots.
// ----------------------------------------------------------------------------
`include "multi_class_two_priority_queue_core_defines.svh"

module multi_class_two_priority_queue_core #(
   parameter int QUEUE_COUNT = 32,
   parameter int QUEUE_DEPTH = 8,
   parameter int ID_WIDTH    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // queue_index [4:0], item_id [20:5], zero pad [23:21]
   input  logic [mctpq_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode [0], urgent [1]
   input  logic [mctpq_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // popped_id [15:0], popped_urgent [16], occupancy [20:17], zero pad [23:21]
   output logic [mctpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_status [1:0]
   output logic [mctpq_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mctpq_pkg::*;

   localparam int QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int SW  = HW + CW;
   localparam int EW  = ID_WIDTH + 1;
   localparam int ED  = QUEUE_COUNT * QUEUE_DEPTH;
   localparam int EAW = (ED > 1) ? $clog2(ED) : 1;
   localparam int TW  = ((HW > CW) ? HW : CW) + 1;

   // wrap of the 5-bit queue index into the bank
   logic [QW-1:0] qmap [QIDX_SPAN];
   for (genvar i = 0; i < QIDX_SPAN; i++) begin : g_qmap
      assign qmap[i] = QW'(i % QUEUE_COUNT);
   end

   // request fields
   logic [QIDX_W-1:0]     req_qidx;
   logic [ID_FIELD_W-1:0] req_id;
   logic [QW-1:0]         req_q;
   assign req_qidx = req_tdata[QIDX_W-1:0];
   assign req_id   = req_tdata[QIDX_W +: ID_FIELD_W];
   assign req_q    = qmap[req_qidx];

   // held command
   logic                mode_ff;
   logic                urgent_ff;
   logic [ID_WIDTH-1:0] id_ff;
   logic [QW-1:0]       q_ff;

   // per-queue valid bits: a queue never written reads as empty
   logic [QUEUE_COUNT-1:0] qvalid_ff;
   logic                   qs_valid_ff;

   fsm_status_type fsm_status;
   fsm_ctrl_type   ctrl;

   logic           req_fire;
   logic           out_free;

   // queue-state RAM
   logic           qs_wr_en;
   logic [SW-1:0]  qs_wr_data;
   logic [SW-1:0]  qs_rd_data;
   logic [HW-1:0]  qs_head;
   logic [CW-1:0]  qs_cnt;

   // entry RAM
   logic           ent_wr_en;
   logic [EAW-1:0] ent_wr_addr;
   logic [EW-1:0]  ent_wr_data;
   logic [EAW-1:0] ent_rd_addr;
   logic [EW-1:0]  ent_rd_data;

   // command evaluation
   logic           is_remove;
   logic           q_full;
   logic           q_empty;
   logic           reject;
   logic           take_entry;
   status_type     exec_status;
   logic [HW-1:0]  head_dec;
   logic [HW-1:0]  head_inc;
   logic [TW-1:0]  head_inc_sum;
   logic [TW-1:0]  tail_sum;
   logic [HW-1:0]  tail_slot;
   logic [HW-1:0]  wr_slot;
   logic [HW-1:0]  new_head;
   logic [CW-1:0]  new_cnt;
   logic [EAW-1:0] q_base;

   // occupancy after a pop, kept across the entry read
   logic [CW-1:0]  pend_occ_ff;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   logic [ID_FIELD_W-1:0] rsp_id_ff;
   logic                  rsp_urg_ff;
   logic [OCC_W-1:0]      rsp_occ_ff;

   assign req_tready = ctrl.req_ready;
   assign req_fire   = req_tvalid & ctrl.req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign fsm_status.req_fire   = req_fire;
   assign fsm_status.take_entry = take_entry;
   assign fsm_status.out_free   = out_free;

   mctpq_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .status (fsm_status),
      .ctrl   (ctrl)
   );

   // latch the command and the valid bit of its queue with the state read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff   <= req_tuser[0];
         urgent_ff <= req_tuser[1];
         id_ff     <= ID_WIDTH'(req_id);
         q_ff      <= req_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qvalid_ff   <= '0;
         qs_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            qs_valid_ff <= qvalid_ff[req_q];
         end
         if (qs_wr_en) begin
            qvalid_ff[q_ff] <= 1'b1;
         end
      end
   end

   mctpq_ram #(
      .WIDTH (SW),
      .DEPTH (QUEUE_COUNT)
   ) u_qstate_ram (
      .clock   (clock),
      .wr_en   (qs_wr_en),
      .wr_addr (q_ff),
      .wr_data (qs_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_q),
      .rd_data (qs_rd_data)
   );

   // an unwritten queue reads as head zero, count zero
   assign qs_head = qs_valid_ff ? qs_rd_data[SW-1 -: HW] : '0;
   assign qs_cnt  = qs_valid_ff ? qs_rd_data[CW-1:0]     : '0;

   assign is_remove = (mode_ff == MODE_REMOVE);
   assign q_full    = (qs_cnt >= CW'(QUEUE_DEPTH));
   assign q_empty   = (qs_cnt == '0);
   assign reject    = is_remove ? q_empty : q_full;
   assign take_entry = is_remove & ~q_empty;

   always_comb begin
      priority if (is_remove) begin
         exec_status = q_empty ? ST_EMPTY : ST_DONE;
      end else begin
         exec_status = q_full ? ST_FULL : ST_DONE;
      end
   end

   // circular slot arithmetic, one wrap compare each, no modulo
   assign head_dec     = (qs_head == '0) ? HW'(QUEUE_DEPTH - 1) : qs_head - HW'(1);
   assign head_inc_sum = TW'(qs_head) + TW'(1);
   assign head_inc     = (head_inc_sum >= TW'(QUEUE_DEPTH)) ? '0 : head_inc_sum[HW-1:0];
   assign tail_sum     = TW'(qs_head) + TW'(qs_cnt);
   assign tail_slot    = (tail_sum >= TW'(QUEUE_DEPTH)) ?
                         HW'(tail_sum - TW'(QUEUE_DEPTH)) : HW'(tail_sum);
   assign wr_slot      = urgent_ff ? head_dec : tail_slot;

   always_comb begin
      new_head = qs_head;
      new_cnt  = qs_cnt;
      if (!reject) begin
         priority if (is_remove) begin
            new_head = head_inc;
            new_cnt  = qs_cnt - CW'(1);
         end else begin
            new_head = urgent_ff ? head_dec : qs_head;
            new_cnt  = qs_cnt + CW'(1);
         end
      end
   end

   assign q_base = EAW'(q_ff) * EAW'(QUEUE_DEPTH);

   // write back queue state and the new entry on commit
   assign qs_wr_en    = ctrl.exec_commit & ~reject;
   assign qs_wr_data  = {new_head, new_cnt};
   assign ent_wr_en   = ctrl.exec_commit & ~is_remove & ~q_full;
   assign ent_wr_addr = q_base + EAW'(wr_slot);
   assign ent_wr_data = {urgent_ff, id_ff};
   assign ent_rd_addr = q_base + EAW'(qs_head);

   mctpq_ram #(
      .WIDTH (EW),
      .DEPTH (ED)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ctrl.pop_read),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctrl.pop_read) begin
         pend_occ_ff <= new_cnt;
      end
   end

   // output register: load on result, drop on take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (ctrl.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.result_load) begin
         if (ctrl.from_pop) begin
            rsp_status_ff <= ST_DONE;
            rsp_id_ff     <= ID_FIELD_W'(ent_rd_data[ID_WIDTH-1:0]);
            rsp_urg_ff    <= ent_rd_data[EW-1];
            rsp_occ_ff    <= OCC_W'(pend_occ_ff);
         end else begin
            rsp_status_ff <= exec_status;
            rsp_id_ff     <= '0;
            rsp_urg_ff    <= 1'b0;
            rsp_occ_ff    <= OCC_W'(new_cnt);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_occ_ff, rsp_urg_ff, rsp_id_ff});
   assign rsp_tuser  = rsp_status_ff;

   `MCTPQ_ASSERT_NOW(a_cnt_in_range, clock, reset, ctrl.exec_commit,
      qs_cnt <= CW'(QUEUE_DEPTH), "queue count beyond depth")
   `MCTPQ_ASSERT_NOW(a_no_write_on_full, clock, reset, ent_wr_en,
      !q_full && !is_remove, "entry written on full queue or remove")
   `MCTPQ_ASSERT_NEXT(a_pop_blocks_input, clock, reset, ctrl.pop_read,
      !req_tready && ctrl.from_pop, "entry read not followed by pop step")
   `MCTPQ_ASSERT_NOW(a_reject_no_item, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_DONE),
      (rsp_id_ff == '0) && !rsp_urg_ff, "rejected command reports an item")

endmodule
